/* src/lkvc_pkg.sv */
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;
    localparam logic signed [VAL_W-1:0] PUT_VALUE = 32'sd0;

    typedef enum logic
    {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } lkvc_cmd_t;

    typedef struct packed
    {
        lkvc_cmd_t               command;
        logic signed [KEY_W-1:0] lookup_key;
        logic signed [VAL_W-1:0] write_value;
    } lkvc_req_t;

    typedef struct packed
    {
        logic                    found;
        logic signed [VAL_W-1:0] read_value;
    } lkvc_rsp_t;

    typedef struct packed
    {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } lkvc_entry_t;

    // Broadcast to every cell for the transfer being taken this cycle.
    typedef struct packed
    {
        logic update;
        logic hit_mode;
        logic evict;
    } lkvc_ctrl_t;

endpackage

/* src/lkvc_cell.sv */
`timescale 1ns / 1ps

module lkvc_cell
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [lkvc_pkg::KEY_W-1:0] lookup_key,
    input  lkvc_pkg::lkvc_ctrl_t              ctrl,
    input  lkvc_pkg::lkvc_entry_t             prev_entry,
    output lkvc_pkg::lkvc_entry_t             entry,
    input  logic                              match_in,
    input  logic signed [lkvc_pkg::VAL_W-1:0] value_in,
    output logic                              match_out,
    output logic signed [lkvc_pkg::VAL_W-1:0] value_out
);

    import lkvc_pkg::*;

    logic                    valid_reg;
    logic                    valid_next;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic                    hit;
    logic                    load;

    assign hit       = valid_reg && (key_reg == lookup_key);
    assign match_out = match_in | hit;
    assign value_out = value_in | (hit ? value_reg : '0);

    // A cell takes its neighbour's entry when it lies between the front of the
    // chain and the hit, or, on an insert, inside the part of the chain that
    // moves down by one place. On eviction the last valid cell is overwritten.
    always_comb
    begin
        if (ctrl.hit_mode)
        begin
            load = ctrl.update && match_out;
        end
        else if (ctrl.evict)
        begin
            load = ctrl.update && valid_reg;
        end
        else
        begin
            load = ctrl.update && prev_entry.valid;
        end
        valid_next = load ? prev_entry.valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg   <= prev_entry.key;
            value_reg <= prev_entry.value;
        end
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;

endmodule

/* src/lru_key_value_cache.sv */
`timescale 1ns / 1ps

// Channel   Signals                        Direction  Contents
// req       req_valid, req_ready, req      in         command, lookup_key, write_value
// rsp       rsp_valid, rsp_ready, rsp      out        found, read_value
// cfg       cfg_valid, cfg_ready, cfg_data in         capacity_in_use
//
// One request is taken per cycle; its response appears in the response
// register on the next cycle. The speed is set by the parallel key compare in
// the cell chain and the shift of the chain, both done in the cycle of the
// transfer. req_ready drops only while a response is held with rsp_ready low.
// Reset clears all entries and sets the capacity to sixteen; cfg is always ready.

module lru_key_value_cache
#(
    parameter int ENTRIES = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  lkvc_pkg::lkvc_req_t                req,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output lkvc_pkg::lkvc_rsp_t                rsp,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lkvc_pkg::CAP_W-1:0]         cfg_data
);

    import lkvc_pkg::*;

    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [CMPW-1:0] ENT_LIM = CMPW'(ENTRIES);
    localparam logic [CMPW-1:0] CAP_MIN = CMPW'(1);

    // The chain is kept in recency order: cell 0 is the most recent entry.
    lkvc_entry_t             entries [ENTRIES];
    logic                    match   [ENTRIES+1];
    logic signed [VAL_W-1:0] value_c [ENTRIES+1];

    logic [CAP_W-1:0] cap_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    lkvc_rsp_t        rsp_reg;
    lkvc_rsp_t        rsp_next;

    logic             accept;
    logic             is_put;
    logic             any_hit;
    logic [CMPW-1:0]  cap_ext;
    logic [CMPW-1:0]  eff_cap;
    lkvc_ctrl_t       ctrl;
    lkvc_entry_t      head;

    assign accept    = req_valid && req_ready;
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign cfg_ready = 1'b1;
    assign is_put    = (req.command == CMD_PUT);
    assign any_hit   = match[0];

    assign match[ENTRIES]   = 1'b0;
    assign value_c[ENTRIES] = '0;

    always_comb
    begin
        cap_ext = CMPW'(cap_reg);
        if (cap_ext < CAP_MIN)
        begin
            eff_cap = CAP_MIN;
        end
        else if (cap_ext > ENT_LIM)
        begin
            eff_cap = ENT_LIM;
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    always_comb
    begin
        ctrl.update   = accept && (any_hit || is_put);
        ctrl.hit_mode = any_hit;
        ctrl.evict    = !any_hit && (CMPW'(count_reg) >= eff_cap);

        head.valid = 1'b1;
        head.key   = req.lookup_key;
        head.value = is_put ? req.write_value : value_c[0];

        count_next = count_reg;
        if (accept && is_put && !any_hit && !ctrl.evict)
        begin
            count_next = count_reg + CW'(1);
        end

        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (accept)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.found      = any_hit;
            rsp_next.read_value = is_put ? PUT_VALUE : (any_hit ? value_c[0] : MISS_VALUE);
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lkvc_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .lookup_key (req.lookup_key),
            .ctrl       (ctrl),
            .prev_entry ((i == 0) ? head : entries[(i == 0) ? 0 : i - 1]),
            .entry      (entries[i]),
            .match_in   (match[i+1]),
            .value_in   (value_c[i+1]),
            .match_out  (match[i]),
            .value_out  (value_c[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
